@@ hdl/etl_pkg.sv @@
// ----------------------------------------------------------------------------
// etl_pkg
// Types and character codes shared by the expression token lexer files.
// ----------------------------------------------------------------------------
package etl_pkg;

    localparam int TOKEN_VALUE_W = 32;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        KIND_NUMBER  = 4'd0,
        KIND_OPEN    = 4'd1,
        KIND_CLOSE   = 4'd2,
        KIND_OPER    = 4'd3,
        KIND_IF      = 4'd4,
        KIND_THEN    = 4'd5,
        KIND_ELSE    = 4'd6,
        KIND_BADCHAR = 4'd7,
        KIND_BADKW   = 4'd8
    } t_kind;

    // keyword match progress inside a word
    typedef enum logic [3:0] {
        KW_NONE = 4'd0,
        KW_I    = 4'd1,
        KW_IF   = 4'd2,
        KW_T    = 4'd3,
        KW_TH   = 4'd4,
        KW_THE  = 4'd5,
        KW_THEN = 4'd6,
        KW_E    = 4'd7,
        KW_EL   = 4'd8,
        KW_ELS  = 4'd9,
        KW_ELSE = 4'd10
    } t_kw;

    typedef struct packed {
        t_kind                    kind;
        logic [TOKEN_VALUE_W-1:0] number_value;
        logic                     overflow;
        logic [7:0]               token_char;
        logic                     last;
    } t_token;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_L  = 8'h6C;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_T  = 8'h74;

endpackage

@@ hdl/etl_char_if.sv @@
// ----------------------------------------------------------------------------
// etl_char_if
// Character channel: one byte or an end-of-input marker per item.
// ----------------------------------------------------------------------------
interface etl_char_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_in;

    modport source (output valid, output op, output char_in, input ready);
    modport sink   (input valid, input op, input char_in, output ready);
endinterface

@@ hdl/etl_tok_if.sv @@
// ----------------------------------------------------------------------------
// etl_tok_if
// Token channel: one lexed token per item.
// ----------------------------------------------------------------------------
interface etl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] number_value;
    logic        overflow;
    logic [7:0]  token_char;
    logic        last;

    modport source (output valid, output kind, output number_value, output overflow,
                    output token_char, output last, input ready);
    modport sink   (input valid, input kind, input number_value, input overflow,
                    input token_char, input last, output ready);
endinterface

@@ hdl/expression_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// expression_token_lexer_core
// Byte-serial lexer for arithmetic expressions with if/then/else keywords.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one item per byte (op = 0) or an end-of-input marker
//   (op = 1) that flushes a pending number or word. o_tok carries tokens,
//   one per item, with last set on the final token a given input item caused.
//   A token is registered in the output queue when the input item that
//   completes it is accepted. Throughput: one input item per cycle while each
//   item yields at most one token and o_tok keeps up; a byte that both ends a
//   number/word and forms a token of its own yields two tokens, which leave
//   one after the other. The rate is set by the single token per cycle of the
//   four-entry output queue: i_char.ready is high while it has room for two.
//   Reset (synchronous, active low) returns the lexer to idle between
//   tokens and empties the queue. When o_tok stalls, tokens collect in the
//   queue and i_char.ready drops once fewer than two entries are free; no
//   token is lost or repeated.
// ----------------------------------------------------------------------------
module expression_token_lexer_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    etl_char_if.sink   i_char,
    etl_tok_if.source  o_tok
);

    logic            fire;
    logic            room2;
    logic [1:0]      push_n;
    etl_pkg::t_token tok0, tok1, head;

    assign i_char.ready = room2;
    assign fire         = i_char.valid && room2;

    etl_lexer #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_op      (i_char.op),
        .i_char_in (i_char.char_in),
        .o_push_n  (push_n),
        .o_tok0    (tok0),
        .o_tok1    (tok1)
    );

    etl_tok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_tok0   (tok0),
        .i_tok1   (tok1),
        .o_room2  (room2),
        .o_valid  (o_tok.valid),
        .i_ready  (o_tok.ready),
        .o_head   (head)
    );

    assign o_tok.kind         = head.kind;
    assign o_tok.number_value = head.number_value;
    assign o_tok.overflow     = head.overflow;
    assign o_tok.token_char   = head.token_char;
    assign o_tok.last         = head.last;

endmodule

@@ hdl/etl_lexer.sv @@
// ----------------------------------------------------------------------------
// etl_lexer
// Lexer state and per-byte token logic; yields up to two tokens per item.
// ----------------------------------------------------------------------------
module etl_lexer #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_op,
    input  logic [7:0]      i_char_in,
    output logic [1:0]      o_push_n,
    output etl_pkg::t_token o_tok0,
    output etl_pkg::t_token o_tok1
);

    localparam int WideW = VALUE_WIDTH + 4;
    localparam int OutW  = (VALUE_WIDTH < etl_pkg::TOKEN_VALUE_W) ? VALUE_WIDTH
                                                                  : etl_pkg::TOKEN_VALUE_W;

    etl_pkg::t_mode         r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_ovf, n_ovf;
    etl_pkg::t_kw           r_kw, n_kw;

    logic                   is_digit, is_skip, is_wspace;
    logic [3:0]             dig;
    logic [WideW-1:0]       acc_x, prod;
    logic                   prod_ovf;

    logic                   id_emit;
    etl_pkg::t_token        id_tok;
    etl_pkg::t_mode         id_mode;
    etl_pkg::t_kw           id_kw;
    logic [VALUE_WIDTH-1:0] id_num;

    etl_pkg::t_token        fl_tok;
    logic                   use_fl, use_id;

    function automatic etl_pkg::t_kw advance_kw(etl_pkg::t_kw p, logic [7:0] c);
        etl_pkg::t_kw r;
        r = etl_pkg::KW_NONE;
        unique case (p)
            etl_pkg::KW_I:   if (c == etl_pkg::CH_LC_F) r = etl_pkg::KW_IF;
            etl_pkg::KW_T:   if (c == etl_pkg::CH_LC_H) r = etl_pkg::KW_TH;
            etl_pkg::KW_TH:  if (c == etl_pkg::CH_LC_E) r = etl_pkg::KW_THE;
            etl_pkg::KW_THE: if (c == etl_pkg::CH_LC_N) r = etl_pkg::KW_THEN;
            etl_pkg::KW_E:   if (c == etl_pkg::CH_LC_L) r = etl_pkg::KW_EL;
            etl_pkg::KW_EL:  if (c == etl_pkg::CH_LC_S) r = etl_pkg::KW_ELS;
            etl_pkg::KW_ELS: if (c == etl_pkg::CH_LC_E) r = etl_pkg::KW_ELSE;
            default:         r = etl_pkg::KW_NONE;
        endcase
        return r;
    endfunction

    assign is_digit  = (i_char_in >= etl_pkg::CH_ZERO) && (i_char_in <= etl_pkg::CH_NINE);
    assign is_skip   = (i_char_in == etl_pkg::CH_SPACE) || (i_char_in == etl_pkg::CH_LF) ||
                       (i_char_in == etl_pkg::CH_CR);
    assign is_wspace = is_skip || (i_char_in == etl_pkg::CH_TAB) ||
                       (i_char_in == etl_pkg::CH_VT) || (i_char_in == etl_pkg::CH_FF);
    assign dig       = i_char_in[3:0];

    // acc*10 + digit in a widened word; any carry into the top nibble saturates
    assign acc_x    = {4'b0000, r_acc};
    assign prod     = (acc_x << 3) + (acc_x << 1) + WideW'(dig);
    assign prod_ovf = |prod[WideW-1 -: 4];

    // byte lexed from the idle mode
    always_comb begin
        id_emit = 1'b0;
        id_tok  = '0;
        id_mode = etl_pkg::MODE_IDLE;
        id_kw   = etl_pkg::KW_NONE;
        id_num  = '0;
        priority if (is_skip) begin
            id_emit = 1'b0;
        end else if (is_digit) begin
            id_mode = etl_pkg::MODE_NUM;
            id_num  = VALUE_WIDTH'(dig);
        end else if (i_char_in == etl_pkg::CH_LPAREN) begin
            id_emit     = 1'b1;
            id_tok.kind = etl_pkg::KIND_OPEN;
        end else if (i_char_in == etl_pkg::CH_RPAREN) begin
            id_emit     = 1'b1;
            id_tok.kind = etl_pkg::KIND_CLOSE;
        end else if ((i_char_in == etl_pkg::CH_PLUS) || (i_char_in == etl_pkg::CH_MINUS) ||
                     (i_char_in == etl_pkg::CH_STAR) || (i_char_in == etl_pkg::CH_SLASH) ||
                     (i_char_in == etl_pkg::CH_DOLLAR)) begin
            id_emit           = 1'b1;
            id_tok.kind       = etl_pkg::KIND_OPER;
            id_tok.token_char = i_char_in;
        end else if (i_char_in == etl_pkg::CH_LC_I) begin
            id_mode = etl_pkg::MODE_WORD;
            id_kw   = etl_pkg::KW_I;
        end else if (i_char_in == etl_pkg::CH_LC_T) begin
            id_mode = etl_pkg::MODE_WORD;
            id_kw   = etl_pkg::KW_T;
        end else if (i_char_in == etl_pkg::CH_LC_E) begin
            id_mode = etl_pkg::MODE_WORD;
            id_kw   = etl_pkg::KW_E;
        end else begin
            id_emit           = 1'b1;
            id_tok.kind       = etl_pkg::KIND_BADCHAR;
            id_tok.token_char = i_char_in;
        end
    end

    // pending number or word as a token
    always_comb begin
        fl_tok = '0;
        if (r_mode == etl_pkg::MODE_NUM) begin
            fl_tok.kind         = etl_pkg::KIND_NUMBER;
            fl_tok.number_value = etl_pkg::TOKEN_VALUE_W'(r_acc[OutW-1:0]);
            fl_tok.overflow     = r_ovf;
        end else begin
            priority case (r_kw)
                etl_pkg::KW_IF:   fl_tok.kind = etl_pkg::KIND_IF;
                etl_pkg::KW_THEN: fl_tok.kind = etl_pkg::KIND_THEN;
                etl_pkg::KW_ELSE: fl_tok.kind = etl_pkg::KIND_ELSE;
                default:          fl_tok.kind = etl_pkg::KIND_BADKW;
            endcase
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        n_kw   = r_kw;
        use_fl = 1'b0;
        use_id = 1'b0;
        if (i_op) begin
            use_fl = (r_mode != etl_pkg::MODE_IDLE);
            n_mode = etl_pkg::MODE_IDLE;
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_kw   = etl_pkg::KW_NONE;
        end else begin
            unique case (r_mode)
                etl_pkg::MODE_NUM: begin
                    if (is_digit) begin
                        if (prod_ovf) begin
                            n_acc = {VALUE_WIDTH{1'b1}};
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[VALUE_WIDTH-1:0];
                        end
                    end else begin
                        use_fl = 1'b1;
                        use_id = 1'b1;
                    end
                end
                etl_pkg::MODE_WORD: begin
                    if (is_wspace) begin
                        use_fl = 1'b1;
                        use_id = 1'b1;
                    end else begin
                        n_kw = advance_kw(r_kw, i_char_in);
                    end
                end
                default: begin
                    use_id = 1'b1;
                end
            endcase
            // terminating byte is relexed from idle
            if (use_id) begin
                n_mode = id_mode;
                n_acc  = id_num;
                n_ovf  = 1'b0;
                n_kw   = id_kw;
                use_id = id_emit;
            end
        end
    end

    always_comb begin
        o_tok0      = use_fl ? fl_tok : id_tok;
        o_tok0.last = !(use_fl && use_id);
        o_tok1      = id_tok;
        o_tok1.last = 1'b1;
        o_push_n    = i_fire ? (2'(use_fl) + 2'(use_id)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= etl_pkg::MODE_IDLE;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_kw   <= etl_pkg::KW_NONE;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_kw   <= n_kw;
        end
    end

endmodule

@@ hdl/etl_tok_fifo.sv @@
// ----------------------------------------------------------------------------
// etl_tok_fifo
// Four-entry token queue; takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module etl_tok_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_n,
    input  etl_pkg::t_token i_tok0,
    input  etl_pkg::t_token i_tok1,
    output logic            o_room2,
    output logic            o_valid,
    input  logic            i_ready,
    output etl_pkg::t_token o_head
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    etl_pkg::t_token r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_count <= CntW'(Depth - 2));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_tok0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr_ptr + PtrW'(1)] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(i_push_n);
            r_rd_ptr <= r_rd_ptr + PtrW'(pop);
            r_count  <= r_count + CntW'(i_push_n) - CntW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("token queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk)
        i_rst_n |=> (!i_rst_n ||
                     r_count == $past(r_count) + CntW'($past(i_push_n)) - CntW'($past(pop))))
        else $error("token queue count out of step with push and pop");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PtrW'(r_wr_ptr - r_rd_ptr) == r_count[PtrW-1:0])
        else $error("token queue pointers disagree with count");

endmodule

@@ verif/tb_expression_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// tb_expression_token_lexer_core
// Drives character items into the lexer, predicts the token stream in step
// with every accepted item and checks each token leaving o_tok in order.
// The sender runs in bursts and the token sink stalls in varying patterns,
// with one long hold-off that fills the output queue.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_END      = 1'b1;
    localparam int   CYCLE_LIMIT = 200_000;
    localparam int   HOLD_CYCLES = 300;
    localparam int   RANDOM_ITEMS = 1000;

    logic i_clk;
    logic i_rst_n;

    etl_char_if char_if ();
    etl_tok_if  tok_if ();

    expression_token_lexer_core #(
        .VALUE_WIDTH(etl_pkg::TOKEN_VALUE_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_tok   (tok_if)
    );

    // predicted lexer state
    etl_pkg::t_mode lx_mode      = etl_pkg::MODE_IDLE;
    logic [31:0]    lx_value     = '0;
    logic           lx_saturated = 1'b0;
    etl_pkg::t_kw   lx_kw        = etl_pkg::KW_NONE;

    etl_pkg::t_token pending_tokens[$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   burst_left  = 0;
    logic hold_active;
    event hold_start;

    string kw_names[3] = '{"if", "then", "else"};

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------------
    task automatic push_token(input etl_pkg::t_kind kind, input logic [31:0] value,
                              input logic ovf, input logic [7:0] ch, inout int made);
        etl_pkg::t_token tok;
        tok.kind         = kind;
        tok.number_value = value;
        tok.overflow     = ovf;
        tok.token_char   = ch;
        tok.last         = 1'b0;
        pending_tokens.push_back(tok);
        made++;
    endtask

    task automatic flush_pending(inout int made);
        etl_pkg::t_kind kind;
        if (lx_mode == etl_pkg::MODE_NUM) begin
            push_token(etl_pkg::KIND_NUMBER, lx_value, lx_saturated, 8'h00, made);
        end else if (lx_mode == etl_pkg::MODE_WORD) begin
            case (lx_kw)
                etl_pkg::KW_IF:   kind = etl_pkg::KIND_IF;
                etl_pkg::KW_THEN: kind = etl_pkg::KIND_THEN;
                etl_pkg::KW_ELSE: kind = etl_pkg::KIND_ELSE;
                default:          kind = etl_pkg::KIND_BADKW;
            endcase
            push_token(kind, 32'd0, 1'b0, 8'h00, made);
        end
        lx_mode      = etl_pkg::MODE_IDLE;
        lx_value     = '0;
        lx_saturated = 1'b0;
        lx_kw        = etl_pkg::KW_NONE;
    endtask

    task automatic lex_idle_char(input logic [7:0] ch, inout int made);
        lx_mode = etl_pkg::MODE_IDLE;
        if (ch inside {etl_pkg::CH_SPACE, etl_pkg::CH_LF, etl_pkg::CH_CR}) begin
            // skipped between tokens
        end else if (ch inside {[etl_pkg::CH_ZERO:etl_pkg::CH_NINE]}) begin
            lx_mode      = etl_pkg::MODE_NUM;
            lx_value     = 32'(ch - etl_pkg::CH_ZERO);
            lx_saturated = 1'b0;
        end else if (ch == etl_pkg::CH_LPAREN) begin
            push_token(etl_pkg::KIND_OPEN, 32'd0, 1'b0, 8'h00, made);
        end else if (ch == etl_pkg::CH_RPAREN) begin
            push_token(etl_pkg::KIND_CLOSE, 32'd0, 1'b0, 8'h00, made);
        end else if (ch inside {etl_pkg::CH_PLUS, etl_pkg::CH_MINUS, etl_pkg::CH_STAR,
                                etl_pkg::CH_SLASH, etl_pkg::CH_DOLLAR}) begin
            push_token(etl_pkg::KIND_OPER, 32'd0, 1'b0, ch, made);
        end else if (ch == etl_pkg::CH_LC_I) begin
            lx_mode = etl_pkg::MODE_WORD;
            lx_kw   = etl_pkg::KW_I;
        end else if (ch == etl_pkg::CH_LC_T) begin
            lx_mode = etl_pkg::MODE_WORD;
            lx_kw   = etl_pkg::KW_T;
        end else if (ch == etl_pkg::CH_LC_E) begin
            lx_mode = etl_pkg::MODE_WORD;
            lx_kw   = etl_pkg::KW_E;
        end else begin
            push_token(etl_pkg::KIND_BADCHAR, 32'd0, 1'b0, ch, made);
        end
    endtask

    task automatic lex_predict(input logic op, input logic [7:0] ch);
        int              made;
        logic [31:0]     digit;
        etl_pkg::t_token tail;
        made = 0;
        if (op == OP_END) begin
            flush_pending(made);
        end else if (lx_mode == etl_pkg::MODE_NUM) begin
            if (ch inside {[etl_pkg::CH_ZERO:etl_pkg::CH_NINE]}) begin
                digit = 32'(ch - etl_pkg::CH_ZERO);
                if (lx_value > (32'hFFFF_FFFF - digit) / 32'd10) begin
                    lx_value     = 32'hFFFF_FFFF;
                    lx_saturated = 1'b1;
                end else begin
                    lx_value = lx_value * 32'd10 + digit;
                end
            end else begin
                flush_pending(made);
                lex_idle_char(ch, made);
            end
        end else if (lx_mode == etl_pkg::MODE_WORD) begin
            if (ch inside {etl_pkg::CH_SPACE, etl_pkg::CH_TAB, etl_pkg::CH_LF,
                           etl_pkg::CH_VT, etl_pkg::CH_FF, etl_pkg::CH_CR}) begin
                flush_pending(made);
                lex_idle_char(ch, made);
            end else begin
                case (lx_kw)
                    etl_pkg::KW_I:
                        lx_kw = (ch == etl_pkg::CH_LC_F) ? etl_pkg::KW_IF : etl_pkg::KW_NONE;
                    etl_pkg::KW_T:
                        lx_kw = (ch == etl_pkg::CH_LC_H) ? etl_pkg::KW_TH : etl_pkg::KW_NONE;
                    etl_pkg::KW_TH:
                        lx_kw = (ch == etl_pkg::CH_LC_E) ? etl_pkg::KW_THE : etl_pkg::KW_NONE;
                    etl_pkg::KW_THE:
                        lx_kw = (ch == etl_pkg::CH_LC_N) ? etl_pkg::KW_THEN : etl_pkg::KW_NONE;
                    etl_pkg::KW_E:
                        lx_kw = (ch == etl_pkg::CH_LC_L) ? etl_pkg::KW_EL : etl_pkg::KW_NONE;
                    etl_pkg::KW_EL:
                        lx_kw = (ch == etl_pkg::CH_LC_S) ? etl_pkg::KW_ELS : etl_pkg::KW_NONE;
                    etl_pkg::KW_ELS:
                        lx_kw = (ch == etl_pkg::CH_LC_E) ? etl_pkg::KW_ELSE : etl_pkg::KW_NONE;
                    default:
                        lx_kw = etl_pkg::KW_NONE;
                endcase
            end
        end else begin
            lex_idle_char(ch, made);
        end
        if (made > 0) begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
        end
        burst_left--;
        char_if.valid   <= 1'b1;
        char_if.op      <= op;
        char_if.char_in <= ch;
        do @(posedge i_clk); while (char_if.ready !== 1'b1);
        items_sent++;
        lex_predict(op, ch);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
    endtask

    // sender pauses until every predicted token has come out
    task automatic wait_drain();
        char_if.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // any byte that keeps a word going
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c inside {etl_pkg::CH_SPACE, etl_pkg::CH_TAB, etl_pkg::CH_LF,
                      etl_pkg::CH_VT, etl_pkg::CH_FF, etl_pkg::CH_CR})
            c = etl_pkg::CH_LC_S;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stall density changes from phase to phase
    // ------------------------------------------------------------------------
    initial begin
        int stall_pct;
        int phase_left;
        tok_if.ready <= 1'b0;
        stall_pct  = 0;
        phase_left = 0;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                phase_left = $urandom_range(20, 150);
            end
            phase_left--;
            if (hold_active) tok_if.ready <= 1'b0;
            else tok_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // long hold-off on the token side
    initial begin
        hold_active <= 1'b0;
        forever begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        $display("%0t: token %s expected 0x%0h got 0x%0h", $time, field, want_v, got_v);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        etl_pkg::t_token want;
        if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: token kind expected none got 0x%0h", $time, tok_if.kind);
                error_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (tok_if.kind !== want.kind)
                    report_mismatch("kind", 64'(want.kind), 64'(tok_if.kind));
                if (tok_if.number_value !== want.number_value)
                    report_mismatch("number_value", 64'(want.number_value),
                                    64'(tok_if.number_value));
                if (tok_if.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(want.overflow), 64'(tok_if.overflow));
                if (tok_if.token_char !== want.token_char)
                    report_mismatch("token_char", 64'(want.token_char),
                                    64'(tok_if.token_char));
                if (tok_if.last !== want.last)
                    report_mismatch("last", 64'(want.last), 64'(tok_if.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_tokens();
        // saturating number ended by an operator: two tokens from one byte
        send_text("4294967299+");
        send_text("()*-/$");
        // tab ends the word, then is a bad char in idle
        send_text("then");
        send_item(OP_CHAR, etl_pkg::CH_TAB);
        send_text(" \n");
        send_item(OP_CHAR, etl_pkg::CH_CR);
        send_item(OP_CHAR, etl_pkg::CH_VT);
        send_item(OP_CHAR, 8'hFF);
        send_item(OP_CHAR, 8'h00);
        send_text("if");
        send_item(OP_END, 8'h00);
        // end of input while idle gives nothing
        send_item(OP_END, 8'hFF);
    endtask

    task automatic test_output_backpressure();
        -> hold_start;
        repeat (25) send_text("12+");
        wait_drain();
    endtask

    task automatic test_random_stream();
        int          start_count;
        int          len;
        int          pos;
        string       kw;
        logic [63:0] v;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 7) == 0) send_item(OP_CHAR, etl_pkg::CH_ZERO);
                    case ($urandom_range(0, 5))
                        0:       v = 64'($urandom_range(0, 9));
                        1:       v = 64'($urandom_range(0, 99999));
                        2:       v = 64'($urandom());
                        3:       v = 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
                        4:       v = 64'h1_0000_0000 + 64'($urandom_range(0, 20));
                        default: v = 64'hFFFF_FFFF_FFFF_FFFF;
                    endcase
                    if (v == 64'hFFFF_FFFF_FFFF_FFFF) begin
                        len = $urandom_range(11, 20);
                        for (int k = 0; k < len; k++)
                            send_item(OP_CHAR,
                                      etl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    end else begin
                        send_text($sformatf("%0d", v));
                    end
                end
                6, 7, 8: send_text(kw_names[$urandom_range(0, 2)]);
                9, 10: begin
                    kw  = kw_names[$urandom_range(0, 2)];
                    len = kw.len();
                    case ($urandom_range(0, 3))
                        0: send_text(kw.substr(0, $urandom_range(0, len - 2)));
                        1: begin
                            send_text(kw);
                            send_item(OP_CHAR, word_byte());
                        end
                        2: begin
                            pos = $urandom_range(1, len - 1);
                            for (int k = 0; k < len; k++)
                                send_item(OP_CHAR, (k == pos) ? word_byte() : kw[k]);
                        end
                        default: begin
                            send_item(OP_CHAR, kw[0]);
                            repeat ($urandom_range(0, 5)) send_item(OP_CHAR, word_byte());
                        end
                    endcase
                end
                11, 12: begin
                    case ($urandom_range(0, 6))
                        0:       send_item(OP_CHAR, etl_pkg::CH_LPAREN);
                        1:       send_item(OP_CHAR, etl_pkg::CH_RPAREN);
                        2:       send_item(OP_CHAR, etl_pkg::CH_PLUS);
                        3:       send_item(OP_CHAR, etl_pkg::CH_MINUS);
                        4:       send_item(OP_CHAR, etl_pkg::CH_STAR);
                        5:       send_item(OP_CHAR, etl_pkg::CH_SLASH);
                        default: send_item(OP_CHAR, etl_pkg::CH_DOLLAR);
                    endcase
                end
                13, 14: begin
                    case ($urandom_range(0, 8))
                        0, 1, 2: send_item(OP_CHAR, etl_pkg::CH_SPACE);
                        3, 4:    send_item(OP_CHAR, etl_pkg::CH_LF);
                        5:       send_item(OP_CHAR, etl_pkg::CH_CR);
                        6:       send_item(OP_CHAR, etl_pkg::CH_TAB);
                        7:       send_item(OP_CHAR, etl_pkg::CH_VT);
                        default: send_item(OP_CHAR, etl_pkg::CH_FF);
                    endcase
                end
                15, 16: send_item(OP_CHAR, 8'($urandom_range(0, 255)));
                17:     send_item(OP_END, 8'($urandom_range(0, 255)));
                default: send_item(OP_CHAR, etl_pkg::CH_SPACE);
            endcase
            if ($urandom_range(0, 1) == 0) send_item(OP_CHAR, etl_pkg::CH_SPACE);
        end
        send_item(OP_END, 8'h00);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        char_if.valid   <= 1'b0;
        char_if.op      <= OP_CHAR;
        char_if.char_in <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tokens();
        wait_drain();
        test_output_backpressure();
        test_random_stream();
        wait_drain();
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
